[rtl/core/assert_macros.svh]
// Assertion macros used by the top-level module of the vertex normal block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define VNA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define VNA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/vna_pkg.sv]
// Shared types, constants and helper functions of the vertex normal block.
`default_nettype none

package vna_pkg;

  localparam int VERTEX_COUNT = 4096;
  localparam int IDX_W        = 12;
  localparam int POS_W        = 16;
  localparam int ACC_W        = 32;
  localparam int NRM_W        = 16;
  localparam int VEC_W        = 36;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_TRI  = 2'd1,
    MODE_READ = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  // Result of one normalization.
  typedef struct packed {
    logic                    deg;
    logic signed [NRM_W-1:0] x;
    logic signed [NRM_W-1:0] y;
    logic signed [NRM_W-1:0] z;
  } norm_res_t;

  // True when a vertex index addresses an existing entry.
  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return ({1'b0, idx} < (IDX_W+1)'(VERTEX_COUNT));
  endfunction

  // Signed accumulator add that clamps to the 32-bit range.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [NRM_W-1:0] n);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + (ACC_W+1)'(n);
    if (s[ACC_W] != s[ACC_W-1]) begin
      return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/core/vna_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds while re is low.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/core/vna_norm.sv]
// Multi-cycle unit that scales a signed vector to a Q1.15 unit vector.
`default_nettype none

module vna_norm (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  input  wire logic signed [vna_pkg::VEC_W-1:0] vec_x,
  input  wire logic signed [vna_pkg::VEC_W-1:0] vec_y,
  input  wire logic signed [vna_pkg::VEC_W-1:0] vec_z,
  output logic                                  done,
  output vna_pkg::norm_res_t                    res
);

  import vna_pkg::*;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQUARE,
    N_ROOT,
    N_DIV_INIT,
    N_DIV,
    N_DONE
  } nstate_t;

  nstate_t                 st;
  logic [VEC_W-1:0]        mag [3];
  logic [VEC_W-1:0]        am  [3];
  logic [2:0]              neg;
  logic [VEC_W-1:0]        mx;
  logic [VEC_W-1:0]        mx_in;
  logic [1:0]              k;
  logic [4:0]              cnt;
  logic [47:0]             prod;
  logic [49:0]             sum;
  logic [50:0]             rad;
  logic [50:0]             root;
  logic [50:0]             rbit;
  logic [50:0]             trial;
  logic [25:0]             len;
  logic [39:0]             num;
  logic [26:0]             rem;
  logic [26:0]             shifted;
  logic [16:0]             quo;
  logic                    qb;
  logic [16:0]             q_next;
  logic signed [NRM_W-1:0] nout [3];
  logic signed [NRM_W-1:0] scaled;
  logic signed [VEC_W-1:0] vin [3];

  assign vin[0] = vec_x;
  assign vin[1] = vec_y;
  assign vin[2] = vec_z;

  // Magnitudes and their maximum at the start beat.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      am[i] = vin[i][VEC_W-1] ? (~vin[i] + 1'b1) : vin[i];
    end
    mx_in = (am[0] > am[1]) ? am[0] : am[1];
    if (am[2] > mx_in) begin
      mx_in = am[2];
    end
  end

  // One step of the bit-pair square root.
  assign trial = root + rbit;
  assign len   = root[25:0];

  // Rounded dividend of the current component and one restoring division step.
  assign num     = {1'b0, mag[k][23:0], 15'd0} + 40'(len[25:1]);
  assign shifted = {rem[25:0], quo[16]};
  assign qb      = (shifted >= {1'b0, len});
  assign q_next  = {quo[15:0], qb};

  // Sign and clamp of the finished quotient.
  always_comb begin
    if (neg[k]) begin
      scaled = NRM_W'(~q_next + 1'b1);
    end else if (q_next > 17'd32767) begin
      scaled = 16'sd32767;
    end else begin
      scaled = q_next[NRM_W-1:0];
    end
  end

  // Sequencer: shift down, sum of squares, square root, then three divisions (or a zero result for a zero length).
  always_ff @(posedge clk) begin
    if (rst) begin
      st   <= N_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= am[i];
              neg[i] <= vin[i][VEC_W-1];
            end
            mx  <= mx_in;
            sum <= '0;
            k   <= 2'd0;
            st  <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (mx[VEC_W-1:24] != '0) begin
            mx <= mx >> 1;
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else begin
            st <= N_SQUARE;
          end
        end
        N_SQUARE: begin
          if (k != 2'd0) begin
            sum <= sum + {2'd0, prod};
          end
          if (k != 2'd3) begin
            prod <= mag[k][23:0] * mag[k][23:0];
            k    <= k + 2'd1;
          end else begin
            rad  <= {1'b0, sum} + {3'd0, prod};
            root <= '0;
            rbit <= 51'd1 << 48;
            cnt  <= '0;
            k    <= 2'd0;
            st   <= N_ROOT;
          end
        end
        N_ROOT: begin
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + rbit;
          end else begin
            root <= root >> 1;
          end
          rbit <= rbit >> 2;
          cnt  <= cnt + 5'd1;
          if (cnt == 5'd24) begin
            st <= N_DIV_INIT;
          end
        end
        N_DIV_INIT: begin
          if (len == '0) begin
            res.deg <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              nout[i] <= '0;
            end
            st <= N_DONE;
          end else begin
            res.deg <= 1'b0;
            rem     <= 27'(num[39:17]);
            quo     <= num[16:0];
            cnt     <= '0;
            st      <= N_DIV;
          end
        end
        N_DIV: begin
          rem <= qb ? (shifted - {1'b0, len}) : shifted;
          quo <= q_next;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd16) begin
            nout[k] <= scaled;
            if (k == 2'd2) begin
              st <= N_DONE;
            end else begin
              k  <= k + 2'd1;
              st <= N_DIV_INIT;
            end
          end
        end
        N_DONE: begin
          res.x <= nout[0];
          res.y <= nout[1];
          res.z <= nout[2];
          done  <= 1'b1;
          st    <= N_IDLE;
        end
        default: begin
          st <= N_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/core/vertex_normal_accumulator.sv]
// Top level: per-vertex position and normal accumulator memories with a command sequencer.
// A load or unused-mode beat is taken in idle and keeps busy low. A read beat strobes its result
// once the normalizer finishes; a triangle beat with all corners in range holds busy until all
// three corner accumulators are written back. Beats are processed one at a time.
// The normalizer works by shift-down, a 25-step square root and three divisions; each vertex
// access has a read state and then a capture or write-back state.
// Synchronous active-high reset idles the sequencer and keeps memories; results never stall.
`default_nettype none
`include "assert_macros.svh"

module vertex_normal_accumulator (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       mode,
  input  wire logic [vna_pkg::IDX_W-1:0]        vertex_a,
  input  wire logic [vna_pkg::IDX_W-1:0]        vertex_b,
  input  wire logic [vna_pkg::IDX_W-1:0]        vertex_c,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_x,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_y,
  input  wire logic signed [vna_pkg::POS_W-1:0] pos_z,
  output logic                                  valid,
  output logic [vna_pkg::IDX_W-1:0]             vertex_index,
  output logic signed [vna_pkg::NRM_W-1:0]      normal_x,
  output logic signed [vna_pkg::NRM_W-1:0]      normal_y,
  output logic signed [vna_pkg::NRM_W-1:0]      normal_z,
  output logic                                  degenerate
);

  import vna_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRD,
    S_PCAP,
    S_CROSS,
    S_TNORM,
    S_ARD,
    S_AWR,
    S_RRD,
    S_RNORM
  } state_t;

  state_t                  st;
  logic                    accept;
  logic [IDX_W-1:0]        a_idx;
  logic [IDX_W-1:0]        b_idx;
  logic [IDX_W-1:0]        c_idx;
  logic [IDX_W-1:0]        corner;
  logic [1:0]              k;
  logic [1:0]              cnt;
  logic [1:0]              cnt_prev;
  logic [3*POS_W-1:0]      p [3];
  logic signed [16:0]      e1 [3];
  logic signed [16:0]      e2 [3];
  logic signed [16:0]      m1a;
  logic signed [16:0]      m1b;
  logic signed [16:0]      m2a;
  logic signed [16:0]      m2b;
  logic signed [33:0]      prod1;
  logic signed [33:0]      prod2;
  logic signed [VEC_W-1:0] cr [3];
  logic                    rd_mode;
  logic                    norm_start;
  logic                    norm_done;
  norm_res_t               norm_out;
  norm_res_t               nres;
  logic signed [VEC_W-1:0] vec_x;
  logic signed [VEC_W-1:0] vec_y;
  logic signed [VEC_W-1:0] vec_z;

  logic                    pos_we;
  logic                    pos_re;
  logic [3*POS_W-1:0]      pos_rdata;
  logic                    load_we;
  logic                    acc_we;
  logic                    acc_re;
  logic [IDX_W-1:0]        acc_waddr;
  logic [IDX_W-1:0]        acc_raddr;
  logic [3*ACC_W-1:0]      acc_wdata;
  logic [3*ACC_W-1:0]      acc_rdata;

  assign busy   = (st != S_IDLE);
  assign accept = start && !busy;

  // Corner address for the current position read or accumulator update.
  always_comb begin
    case (k)
      2'd0:    corner = a_idx;
      2'd1:    corner = b_idx;
      default: corner = c_idx;
    endcase
  end

  // Position memory: written by a load beat, read per triangle corner.
  assign pos_we = accept && (mode == MODE_LOAD) && in_range(vertex_a);
  assign pos_re = (st == S_PRD);

  vna_ram #(
    .WIDTH(3*POS_W),
    .DEPTH(VERTEX_COUNT)
  ) u_pos_ram (
    .clk  (clk),
    .we   (pos_we),
    .waddr(vertex_a),
    .wdata({pos_x, pos_y, pos_z}),
    .re   (pos_re),
    .raddr(corner),
    .rdata(pos_rdata)
  );

  // Accumulator memory: cleared by a load, read-modify-written per corner.
  assign load_we   = pos_we;
  assign acc_we    = load_we || (st == S_AWR);
  assign acc_waddr = load_we ? vertex_a : corner;
  assign acc_wdata = load_we ? '0 :
                     {sat_add(acc_rdata[3*ACC_W-1:2*ACC_W], nres.x),
                      sat_add(acc_rdata[2*ACC_W-1:ACC_W], nres.y),
                      sat_add(acc_rdata[ACC_W-1:0], nres.z)};
  assign acc_re    = (st == S_ARD) || (st == S_RRD);
  assign acc_raddr = (st == S_RRD) ? a_idx : corner;

  vna_ram #(
    .WIDTH(3*ACC_W),
    .DEPTH(VERTEX_COUNT)
  ) u_acc_ram (
    .clk  (clk),
    .we   (acc_we),
    .waddr(acc_waddr),
    .wdata(acc_wdata),
    .re   (acc_re),
    .raddr(acc_raddr),
    .rdata(acc_rdata)
  );

  // Edge vectors from the first corner.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = 17'(signed'(p[1][(2-i)*POS_W +: POS_W])) -
              17'(signed'(p[0][(2-i)*POS_W +: POS_W]));
      e2[i] = 17'(signed'(p[2][(2-i)*POS_W +: POS_W])) -
              17'(signed'(p[0][(2-i)*POS_W +: POS_W]));
    end
  end

  // Cross product operands, one component per cycle.
  always_comb begin
    case (cnt)
      2'd0: begin
        m1a = e1[1]; m1b = e2[2]; m2a = e1[2]; m2b = e2[1];
      end
      2'd1: begin
        m1a = e1[2]; m1b = e2[0]; m2a = e1[0]; m2b = e2[2];
      end
      default: begin
        m1a = e1[0]; m1b = e2[1]; m2a = e1[1]; m2b = e2[0];
      end
    endcase
  end

  assign cnt_prev = cnt - 2'd1;

  // Normalizer input: an accumulator for a read, the cross product otherwise.
  assign vec_x = rd_mode ? VEC_W'(signed'(acc_rdata[3*ACC_W-1:2*ACC_W])) : cr[0];
  assign vec_y = rd_mode ? VEC_W'(signed'(acc_rdata[2*ACC_W-1:ACC_W]))   : cr[1];
  assign vec_z = rd_mode ? VEC_W'(signed'(acc_rdata[ACC_W-1:0]))         : cr[2];

  vna_norm u_norm (
    .clk  (clk),
    .rst  (rst),
    .start(norm_start),
    .vec_x(vec_x),
    .vec_y(vec_y),
    .vec_z(vec_z),
    .done (norm_done),
    .res  (norm_out)
  );

  // Command sequencer and registered result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      valid      <= 1'b0;
      norm_start <= 1'b0;
    end else begin
      valid      <= 1'b0;
      norm_start <= 1'b0;
      case (st)
        S_IDLE: begin
          if (accept) begin
            a_idx <= vertex_a;
            b_idx <= vertex_b;
            c_idx <= vertex_c;
            k     <= 2'd0;
            if (mode == MODE_TRI) begin
              rd_mode <= 1'b0;
              if (in_range(vertex_a) && in_range(vertex_b) && in_range(vertex_c)) begin
                st <= S_PRD;
              end
            end else if (mode == MODE_READ) begin
              rd_mode <= 1'b1;
              if (in_range(vertex_a)) begin
                st <= S_RRD;
              end else begin
                valid        <= 1'b1;
                vertex_index <= vertex_a;
                normal_x     <= '0;
                normal_y     <= '0;
                normal_z     <= '0;
                degenerate   <= 1'b1;
              end
            end
          end
        end
        S_PRD: begin
          st <= S_PCAP;
        end
        S_PCAP: begin
          p[k] <= pos_rdata;
          if (k == 2'd2) begin
            cnt <= 2'd0;
            st  <= S_CROSS;
          end else begin
            k  <= k + 2'd1;
            st <= S_PRD;
          end
        end
        S_CROSS: begin
          if (cnt != 2'd3) begin
            prod1 <= m1a * m1b;
            prod2 <= m2a * m2b;
          end
          if (cnt != 2'd0) begin
            cr[cnt_prev] <= VEC_W'(prod1) - VEC_W'(prod2);
          end
          cnt <= cnt + 2'd1;
          if (cnt == 2'd3) begin
            norm_start <= 1'b1;
            st         <= S_TNORM;
          end
        end
        S_TNORM: begin
          if (norm_done) begin
            nres <= norm_out;
            k    <= 2'd0;
            st   <= S_ARD;
          end
        end
        S_ARD: begin
          st <= S_AWR;
        end
        S_AWR: begin
          if (k == 2'd2) begin
            st <= S_IDLE;
          end else begin
            k  <= k + 2'd1;
            st <= S_ARD;
          end
        end
        S_RRD: begin
          norm_start <= 1'b1;
          st         <= S_RNORM;
        end
        S_RNORM: begin
          if (norm_done) begin
            valid        <= 1'b1;
            vertex_index <= a_idx;
            normal_x     <= norm_out.x;
            normal_y     <= norm_out.y;
            normal_z     <= norm_out.z;
            degenerate   <= norm_out.deg;
            st           <= S_IDLE;
          end
        end
        default: begin
          st <= S_IDLE;
        end
      endcase
    end
  end

  // A triangle beat always occupies the sequencer on the next cycle.
  `VNA_ASSERT_NXT(a_tri_busy, clk, rst, accept && (mode == MODE_TRI), busy, "triangle beat did not raise busy")
  // The normalizer only finishes while the sequencer waits for it.
  `VNA_ASSERT_IMP(a_norm_owner, clk, rst, norm_done, (st == S_TNORM) || (st == S_RNORM), "normalizer finished with no waiter")
  // Accumulator writes come only from a load or a corner write-back.
  `VNA_ASSERT_IMP(a_acc_write, clk, rst, acc_we, (st == S_IDLE) || (st == S_AWR), "stray accumulator write")
  // A result beat leaves the sequencer idle.
  `VNA_ASSERT_IMP(a_valid_idle, clk, rst, valid, !busy, "result beat while busy")

endmodule

`default_nettype wire

[tb/vertex_normal_accumulator_tb.sv]
// Self-checking testbench for the vertex normal accumulator: directed table, then random mesh traffic.
`timescale 1ns / 1ps

module vertex_normal_accumulator_tb;
  import vna_pkg::*;

  localparam int NUM_RANDOM  = 1200;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 250;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic signed [NRM_W-1:0] nx;
    logic signed [NRM_W-1:0] ny;
    logic signed [NRM_W-1:0] nz;
    logic                    deg;
  } normal_beat_t;

  typedef struct {
    mode_t                   op;
    logic [IDX_W-1:0]        a;
    logic [IDX_W-1:0]        b;
    logic [IDX_W-1:0]        c;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
    bit                      typed;
    normal_beat_t            want;
  } cmd_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              mode;
  logic [IDX_W-1:0]        vertex_a;
  logic [IDX_W-1:0]        vertex_b;
  logic [IDX_W-1:0]        vertex_c;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic                    valid;
  logic [IDX_W-1:0]        vertex_index;
  logic signed [NRM_W-1:0] normal_x;
  logic signed [NRM_W-1:0] normal_y;
  logic signed [NRM_W-1:0] normal_z;
  logic                    degenerate;

  // Shadow copy of the vertex memories.
  logic signed [POS_W-1:0] shadow_pos [VERTEX_COUNT][3];
  logic signed [ACC_W-1:0] shadow_acc [VERTEX_COUNT][3];

  normal_beat_t pending_normals[$];
  cmd_row_t     directed_rows[$];
  int mismatches;
  int idle_cycles;
  int n_load, n_tri, n_read, n_none, n_checked;
  bit done_sending;

  vertex_normal_accumulator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .vertex_a(vertex_a), .vertex_b(vertex_b), .vertex_c(vertex_c),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .valid(valid), .vertex_index(vertex_index), .normal_x(normal_x),
    .normal_y(normal_y), .normal_z(normal_z), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Integer square root, digit by digit.
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= root + bitv) begin
        n -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Scales a vector to Q1.15 unit length; returns 1 for a zero-length vector.
  function automatic bit unit_normal(input longint v0, input longint v1, input longint v2,
                                     output logic signed [NRM_W-1:0] n [3]);
    longint          vec [3];
    longint unsigned mag [3];
    longint unsigned peak, total, len, q;
    longint          r;
    int              sh;
    vec = '{v0, v1, v2};
    peak = 0;
    total = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = vec[i] < 0 ? longint'(-vec[i]) : longint'(vec[i]);
      if (mag[i] > peak) peak = mag[i];
    end
    while ((peak >> sh) >= (64'd1 << 24)) sh++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= sh;
      total += mag[i] * mag[i];
    end
    len = int_sqrt(total);
    if (len == 0) begin
      n = '{16'sd0, 16'sd0, 16'sd0};
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 32768 + len / 2) / len;
      if (vec[i] < 0) begin
        r = -longint'(q);
      end else begin
        r = (q > 32767) ? 32767 : longint'(q);
      end
      n[i] = r[NRM_W-1:0];
    end
    return 1'b0;
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp_add(input logic signed [ACC_W-1:0] acc,
                                                        input logic signed [NRM_W-1:0] n);
    longint s;
    s = longint'(acc) + longint'(n);
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[ACC_W-1:0];
  endfunction

  // Applies one accepted command to the shadow memories; returns 1 if it yields a normal.
  function automatic bit mesh_update(input cmd_row_t cmd, output normal_beat_t res);
    longint                  e1 [3];
    longint                  e2 [3];
    logic signed [NRM_W-1:0] n [3];
    logic [IDX_W-1:0]        corner [3];
    res = '{default: '0};
    case (cmd.op)
      MODE_LOAD: begin
        shadow_pos[cmd.a] = '{cmd.x, cmd.y, cmd.z};
        shadow_acc[cmd.a] = '{32'sd0, 32'sd0, 32'sd0};
      end
      MODE_TRI: begin
        for (int i = 0; i < 3; i++) begin
          e1[i] = longint'(shadow_pos[cmd.b][i]) - longint'(shadow_pos[cmd.a][i]);
          e2[i] = longint'(shadow_pos[cmd.c][i]) - longint'(shadow_pos[cmd.a][i]);
        end
        void'(unit_normal(e1[1] * e2[2] - e1[2] * e2[1], e1[2] * e2[0] - e1[0] * e2[2],
                          e1[0] * e2[1] - e1[1] * e2[0], n));
        corner = '{cmd.a, cmd.b, cmd.c};
        for (int k = 0; k < 3; k++)
          for (int i = 0; i < 3; i++)
            shadow_acc[corner[k]][i] = clamp_add(shadow_acc[corner[k]][i], n[i]);
      end
      MODE_READ: begin
        res.deg = unit_normal(shadow_acc[cmd.a][0], shadow_acc[cmd.a][1],
                              shadow_acc[cmd.a][2], n);
        res.idx = cmd.a;
        res.nx = n[0];
        res.ny = n[1];
        res.nz = n[2];
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic cmd_row_t make_cmd(input mode_t op, input int a, input int b, input int c,
                                        input int x, input int y, input int z);
    cmd_row_t r;
    r.op = op;
    r.a = a[IDX_W-1:0];
    r.b = b[IDX_W-1:0];
    r.c = c[IDX_W-1:0];
    r.x = x[POS_W-1:0];
    r.y = y[POS_W-1:0];
    r.z = z[POS_W-1:0];
    r.typed = 1'b0;
    r.want = '{default: '0};
    return r;
  endfunction

  function automatic cmd_row_t make_read(input int a, input int nx, input int ny, input int nz,
                                         input bit deg);
    cmd_row_t r;
    r = make_cmd(MODE_READ, a, 0, 0, 0, 0, 0);
    r.typed = 1'b1;
    r.want = '{a[IDX_W-1:0], nx[NRM_W-1:0], ny[NRM_W-1:0], nz[NRM_W-1:0], deg};
    return r;
  endfunction

  // Drives one beat and waits until the block takes it.
  task automatic issue(input cmd_row_t cmd);
    normal_beat_t res;
    int gap;
    gap = ($urandom_range(0, 9) < 4) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    mode <= cmd.op;
    vertex_a <= cmd.a;
    vertex_b <= cmd.b;
    vertex_c <= cmd.c;
    pos_x <= cmd.x;
    pos_y <= cmd.y;
    pos_z <= cmd.z;
    do @(negedge clk); while (busy);
    @(posedge clk);
    idle_cycles = 0;
    case (cmd.op)
      MODE_LOAD: n_load++;
      MODE_TRI:  n_tri++;
      MODE_READ: n_read++;
      default:   n_none++;
    endcase
    if (mesh_update(cmd, res)) pending_normals.push_back(cmd.typed ? cmd.want : res);
  endtask

  // Compares each strobed normal with the oldest expectation.
  always @(negedge clk) begin
    normal_beat_t w;
    if (!rst && valid) begin
      idle_cycles = 0;
      if (pending_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected normal beat for vertex %0d", vertex_index);
      end else begin
        w = pending_normals.pop_front();
        n_checked++;
        if (vertex_index !== w.idx || normal_x !== w.nx || normal_y !== w.ny ||
            normal_z !== w.nz || degenerate !== w.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: vertex exp %0d got %0d, normal exp (%0d,%0d,%0d) got (%0d,%0d,%0d), deg exp %0b got %0b",
                     w.idx, vertex_index, w.nx, w.ny, w.nz, normal_x, normal_y, normal_z,
                     w.deg, degenerate);
        end
      end
    end
  end

  // Watchdog on cycles with no beat moving in either direction.
  always @(posedge clk) begin
    if (!rst) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("ERROR: no progress for %0d cycles", IDLE_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Random position: mostly full range, sometimes small or at the rails.
  function automatic int pick_coord();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom_range(0, 65535) - 32768;
    if (sel < 8) return $urandom_range(0, 2047) - 1024;
    return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
  endfunction

  initial begin
    int pool [POOL_SIZE];
    int sel, a, b, c;
    cmd_row_t cmd;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_LOAD;
    vertex_a = '0;
    vertex_b = '0;
    vertex_c = '0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    mismatches = 0;
    idle_cycles = 0;
    n_load = 0; n_tri = 0; n_read = 0; n_none = 0; n_checked = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table: unit axes, reversed winding, zero area, extremes, unused mode.
    directed_rows.push_back(make_cmd(MODE_LOAD, 0, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_cmd(MODE_LOAD, 1, 0, 0, 256, 0, 0));
    directed_rows.push_back(make_cmd(MODE_LOAD, 2, 0, 0, 0, 256, 0));
    directed_rows.push_back(make_read(0, 0, 0, 0, 1'b1));
    directed_rows.push_back(make_cmd(MODE_TRI, 0, 1, 2, 0, 0, 0));
    directed_rows.push_back(make_read(0, 0, 0, 32767, 1'b0));
    directed_rows.push_back(make_cmd(MODE_TRI, 0, 0, 1, 0, 0, 0));
    directed_rows.push_back(make_read(1, 0, 0, 32767, 1'b0));
    directed_rows.push_back(make_cmd(MODE_LOAD, 5, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_cmd(MODE_LOAD, 6, 0, 0, 256, 0, 0));
    directed_rows.push_back(make_cmd(MODE_LOAD, 7, 0, 0, 0, 256, 0));
    directed_rows.push_back(make_cmd(MODE_TRI, 5, 7, 6, 0, 0, 0));
    directed_rows.push_back(make_read(6, 0, 0, -32768, 1'b0));
    directed_rows.push_back(make_cmd(MODE_LOAD, 4095, 0, 0, -32768, -32768, -32768));
    directed_rows.push_back(make_cmd(MODE_LOAD, 4094, 0, 0, 32767, 32767, 32767));
    directed_rows.push_back(make_cmd(MODE_LOAD, 4093, 0, 0, -32768, 32767, 0));
    directed_rows.push_back(make_cmd(MODE_TRI, 4095, 4094, 4093, 0, 0, 0));
    directed_rows.push_back(make_cmd(MODE_READ, 4095, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_cmd(MODE_TRI, 4093, 0, 4094, 0, 0, 0));
    directed_rows.push_back(make_cmd(MODE_READ, 4093, 0, 0, 0, 0, 0));
    directed_rows.push_back(make_cmd(MODE_NONE, 4095, 4095, 4095, -1, -1, -1));
    directed_rows.push_back(make_read(2, 0, 0, 32767, 1'b0));
    foreach (directed_rows[i]) issue(directed_rows[i]);

    // Random part: a small vertex pool so normals pile up on shared corners.
    foreach (pool[i]) pool[i] = $urandom_range(0, VERTEX_COUNT - 1);
    pool[0] = 0;
    pool[1] = VERTEX_COUNT - 1;
    foreach (pool[i]) issue(make_cmd(MODE_LOAD, pool[i], $urandom_range(0, 4095),
                                     $urandom_range(0, 4095), pick_coord(), pick_coord(),
                                     pick_coord()));
    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(0, 99);
      a = pool[$urandom_range(0, POOL_SIZE - 1)];
      b = pool[$urandom_range(0, POOL_SIZE - 1)];
      c = pool[$urandom_range(0, POOL_SIZE - 1)];
      if (sel < 12) begin
        if ($urandom_range(0, 3) == 0) begin
          a = $urandom_range(0, VERTEX_COUNT - 1);
          pool[$urandom_range(2, POOL_SIZE - 1)] = a;
        end
        cmd = make_cmd(MODE_LOAD, a, b, c, pick_coord(), pick_coord(), pick_coord());
      end else if (sel < 62) begin
        cmd = make_cmd(MODE_TRI, a, b, c, pick_coord(), pick_coord(), pick_coord());
      end else if (sel < 96) begin
        cmd = make_cmd(MODE_READ, a, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       pick_coord(), pick_coord(), pick_coord());
      end else begin
        cmd = make_cmd(MODE_NONE, $urandom_range(0, 4095), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), pick_coord(), pick_coord(), pick_coord());
        n--;
      end
      issue(cmd);
    end
    start <= 1'b0;

    // Drain the outstanding normals, then let the last command settle.
    while (pending_normals.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Covered %0d loads, %0d triangles, %0d reads and %0d unused-mode beats.",
             n_load, n_tri, n_read, n_none);
    $display("Checked %0d normal beats, %0d mismatches.", n_checked, mismatches);
    if (mismatches == 0 && pending_normals.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
